[hdl/mcsp_pkg.sv]
// mcsp_pkg: word types, action and register codes for the servo pwm block
// no dependencies; imported by mcsp_chan_bank, multi_channel_servo_pwm and the bench
package mcsp_pkg;

	localparam int PIN_BITS = 18;
	localparam logic [15:0] WIDTH_KEEP_HIGH = 16'hFFFF;
	localparam logic [15:0] PERIOD_RESET = 16'd6250;
	localparam logic [7:0] TRIM_RESET = 8'd3;

	// action codes
	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_SET_WIDTH = 3'd1;
	localparam logic [2:0] ACT_SET_LOCK = 3'd2;
	localparam logic [2:0] ACT_ENABLE = 3'd3;
	localparam logic [2:0] ACT_DISABLE = 3'd4;

	// configuration register indexes
	localparam logic CFG_PERIOD_TICKS = 1'b0;
	localparam logic CFG_PULSE_TRIM = 1'b1;

	typedef struct packed {
		logic [2:0] action;
		logic [4:0] channel;
		logic [15:0] value;
	} mcsp_in_t;

	typedef struct packed {
		logic [PIN_BITS-1:0] pin_levels;
		logic period_start;
		logic running;
	} mcsp_out_t;

	// per-step commands from the sequencer to the channel bank
	typedef struct packed {
		logic wr_en;
		logic [4:0] wr_chan;
		logic [15:0] wr_width;
		logic copy;
		logic set_all;
		logic clear_all;
		logic fall_en;
		logic [15:0] count;
	} mcsp_bank_ctl_t;

endpackage

[hdl/multi_channel_servo_pwm.sv]
// multi_channel_servo_pwm: top level, input register, period sequencer, result register
// depends on mcsp_pkg and mcsp_chan_bank
//
// channel   | handshake            | word
// ----------+----------------------+--------------------------------------------
// item      | item_valid/item_stall| mcsp_in_t: action, channel, value
// result    | result_valid/_stall  | mcsp_out_t: pin_levels, period_start, running
// cfg       | cfg_valid/cfg_ready  | cfg_addr (register index), cfg_wdata
//
// one word accepted per cycle while item_stall is low; it is held in the input register, and the
// single pass through the sequencer and comparators loads the result register from it when
// the result register can advance, so the result word comes from the result register behind it
// reset clears control, counter, flags and pins; all widths come up at full scale
// a stalled result holds; the input register still takes one word behind it
// cfg_ready is always high, writes are meant to land while the block is idle
module multi_channel_servo_pwm #(
	parameter int CHANNELS = 18
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input mcsp_pkg::mcsp_in_t item,
	output logic result_valid,
	input logic result_stall,
	output mcsp_pkg::mcsp_out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_addr,
	input logic [15:0] cfg_wdata
);
	import mcsp_pkg::*;

	// configuration registers
	logic [15:0] period_q;
	logic [7:0] trim_q;

	// input register stage
	logic valid_s1;
	mcsp_in_t item_s1;

	// sequencer state
	logic [15:0] count_q;
	logic running_q;
	logic stop_pending_q;
	logic locked_q;

	logic advance;
	logic step;
	logic is_tick;
	logic is_enable;
	logic period_end;
	logic halt;
	logic start;
	logic [15:0] count_nxt;
	logic running_nxt;
	logic [15:0] trimmed;
	mcsp_bank_ctl_t bank_ctl;
	logic [CHANNELS-1:0] pin_nxt;
	logic [PIN_BITS-1:0] pins_vis;

	// input register moves whenever the result register is free or draining
	assign advance = !result_valid || !result_stall;
	assign step = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			trim_q <= TRIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				CFG_PERIOD_TICKS: period_q <= cfg_wdata;
				CFG_PULSE_TRIM: trim_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// tick decode: period ends when the next count reaches or passes the period
	assign is_tick = item_s1.action == ACT_TICK && running_q;
	assign is_enable = item_s1.action == ACT_ENABLE;
	assign period_end = ({1'b0, count_q} + 17'd1) >= {1'b0, period_q};
	assign halt = is_tick && period_end && stop_pending_q;
	assign start = is_tick && period_end && !stop_pending_q;

	always_comb begin
		count_nxt = count_q;
		running_nxt = running_q;
		if (is_tick) begin
			count_nxt = period_end ? 16'd0 : count_q + 16'd1;
			if (halt) begin
				running_nxt = 1'b0;
			end
		end else if (is_enable && !running_q) begin
			// lead-in period with all pins low
			count_nxt = 16'd0;
			running_nxt = 1'b1;
		end
	end

	// requested width less trim, floored at zero
	assign trimmed = (item_s1.value >= {8'd0, trim_q}) ? item_s1.value - {8'd0, trim_q} : 16'd0;

	always_comb begin
		bank_ctl.wr_en = item_s1.action == ACT_SET_WIDTH
			&& {1'b0, item_s1.channel} < 6'(CHANNELS);
		bank_ctl.wr_chan = item_s1.channel;
		bank_ctl.wr_width = trimmed;
		bank_ctl.copy = start && !locked_q;
		bank_ctl.set_all = start;
		bank_ctl.clear_all = is_enable && !running_q;
		bank_ctl.fall_en = is_tick && !halt;
		bank_ctl.count = count_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd0;
			running_q <= 1'b0;
			stop_pending_q <= 1'b0;
			locked_q <= 1'b0;
		end else if (step) begin
			count_q <= count_nxt;
			running_q <= running_nxt;
			case (item_s1.action)
				ACT_SET_LOCK: locked_q <= item_s1.value[0];
				ACT_ENABLE: stop_pending_q <= 1'b0;
				ACT_DISABLE: stop_pending_q <= 1'b1;
				default: ;
			endcase
		end
	end

	mcsp_chan_bank #(
		.CHANNELS(CHANNELS)
	) u_bank (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.ctl(bank_ctl),
		.pin_nxt(pin_nxt)
	);

	// channels past the visible pin field are dropped, missing ones read low
	for (genvar i = 0; i < PIN_BITS; i++) begin : g_vis
		if (i < CHANNELS) begin : g_on
			assign pins_vis[i] = pin_nxt[i];
		end else begin : g_off
			assign pins_vis[i] = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result.pin_levels <= pins_vis;
			result.period_start <= start;
			result.running <= running_nxt;
		end
	end

	// a new period is only ever reported by a running counter
	a_start_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.period_start |-> result.running)
		else $error("period start reported while halted");

	// a halted counter sits at zero
	a_halt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> count_q == 16'd0)
		else $error("counter not zero while halted");

	// the counter only halts on a pending stop
	a_halt_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> $past(stop_pending_q))
		else $error("counter halted without a pending stop");

	// the count never reaches the period while a period is running normally
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_tick && !period_end |=> count_q < period_q || $past(cfg_valid))
		else $error("count ran past the period");

endmodule

[hdl/mcsp_chan_bank.sv]
// mcsp_chan_bank: shadow and active widths, pin levels and fall comparators per channel
// depends on mcsp_pkg
module mcsp_chan_bank #(
	parameter int CHANNELS = 18
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input mcsp_pkg::mcsp_bank_ctl_t ctl,
	output logic [CHANNELS-1:0] pin_nxt
);
	import mcsp_pkg::*;

	logic [15:0] shadow_q [CHANNELS];
	logic [15:0] active_q [CHANNELS];
	logic [15:0] active_nxt [CHANNELS];
	logic [CHANNELS-1:0] pin_q;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		always_comb begin
			active_nxt[i] = ctl.copy ? shadow_q[i] : active_q[i];
			if (ctl.set_all) begin
				pin_nxt[i] = 1'b1;
			end else if (ctl.clear_all) begin
				pin_nxt[i] = 1'b0;
			end else begin
				pin_nxt[i] = pin_q[i];
			end
			// fall once the count reaches the width, full-scale width stays high
			if (ctl.fall_en && active_nxt[i] != WIDTH_KEEP_HIGH && ctl.count >= active_nxt[i]) begin
				pin_nxt[i] = 1'b0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				shadow_q[i] <= WIDTH_KEEP_HIGH;
				active_q[i] <= WIDTH_KEEP_HIGH;
				pin_q[i] <= 1'b0;
			end else if (step) begin
				if (ctl.wr_en && ctl.wr_chan == 5'(i)) begin
					shadow_q[i] <= ctl.wr_width;
				end
				active_q[i] <= active_nxt[i];
				pin_q[i] <= pin_nxt[i];
			end
		end
	end

endmodule

[bench/tb_multi_channel_servo_pwm.sv]
// tb_multi_channel_servo_pwm: self-checking bench for the servo pwm generator
// holds a per-word predictor of the pwm channels and a scoreboard of expected words
// depends on mcsp_pkg and the multi_channel_servo_pwm rtl
`timescale 1ns / 100ps

module tb_multi_channel_servo_pwm;
	import mcsp_pkg::*;

	localparam int CHANNELS = 18;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 150;
	localparam int PHASES = 6;
	localparam int DRAIN_HOLDOFF = 4;
	localparam int END_HOLDOFF = 8;

	// action codes the block must treat as no-ops
	localparam logic [2:0] ACT_RESERVED_5 = 3'd5;
	localparam logic [2:0] ACT_RESERVED_6 = 3'd6;
	localparam logic [2:0] ACT_RESERVED_7 = 3'd7;

	// one row of the directed table; typed rows carry a hand-written result word
	typedef struct {
		mcsp_in_t word;
		bit typed;
		mcsp_out_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	mcsp_in_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	mcsp_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_addr = CFG_PERIOD_TICKS;
	logic [15:0] cfg_wdata = '0;

	// predictor copy of registers and channel state
	logic [15:0] pwm_period;
	logic [7:0] pwm_trim;
	logic [15:0] shadow_w [CHANNELS];
	logic [15:0] active_w [CHANNELS];
	logic [15:0] pwm_count;
	logic pwm_running;
	logic stop_armed;
	logic shadow_lock;
	logic [PIN_BITS-1:0] pwm_pins;

	mcsp_out_t pwm_words_due [$];
	plan_row_t plan [$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	multi_channel_servo_pwm #(
		.CHANNELS(CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// pins whose active width has been reached drop for the rest of the period
	function automatic void drop_expired_pins();
		for (int i = 0; i < CHANNELS; i++) begin
			if (active_w[i] != WIDTH_KEEP_HIGH && pwm_count >= active_w[i])
				pwm_pins[i] = 1'b0;
		end
	endfunction

	// advance the pwm channels by one accepted word, return the word the block should emit
	function automatic mcsp_out_t step_pwm(mcsp_in_t w);
		mcsp_out_t r;
		logic started;
		started = 1'b0;
		case (w.action)
			ACT_TICK: begin
				if (pwm_running) begin
					// counter + 1 at or past the period closes it; period 0 closes every tick
					if ({1'b0, pwm_count} + 17'd1 >= {1'b0, pwm_period}) begin
						if (stop_armed) begin
							// pending stop: counter parks, pins hold their levels
							pwm_running = 1'b0;
							pwm_count = '0;
						end else begin
							pwm_count = '0;
							if (!shadow_lock)
								active_w = shadow_w;
							pwm_pins = '1;
							started = 1'b1;
							drop_expired_pins();
						end
					end else begin
						pwm_count = pwm_count + 16'd1;
						drop_expired_pins();
					end
				end
			end
			ACT_SET_WIDTH: begin
				// trimmed width floors at zero, channels past the bank are dropped
				if (w.channel < CHANNELS)
					shadow_w[w.channel] = (w.value >= {8'd0, pwm_trim}) ?
						w.value - {8'd0, pwm_trim} : 16'd0;
			end
			ACT_SET_LOCK: shadow_lock = w.value[0];
			ACT_ENABLE: begin
				stop_armed = 1'b0;
				if (!pwm_running) begin
					// restart from stop: one dark lead-in period
					pwm_running = 1'b1;
					pwm_count = '0;
					pwm_pins = '0;
				end
			end
			ACT_DISABLE: stop_armed = 1'b1;
			default: ;
		endcase
		r.pin_levels = pwm_pins;
		r.period_start = started;
		r.running = pwm_running;
		return r;
	endfunction

	function automatic plan_row_t mk_row(logic [2:0] act, logic [4:0] ch, logic [15:0] val,
			bit typed, logic [PIN_BITS-1:0] pins, logic ps, logic run);
		plan_row_t p;
		p.word.action = act;
		p.word.channel = ch;
		p.word.value = val;
		p.typed = typed;
		p.want.pin_levels = pins;
		p.want.period_start = ps;
		p.want.running = run;
		return p;
	endfunction

	// random word: mostly ticks and width updates aimed near the period, the rest noise
	function automatic mcsp_in_t rand_word();
		mcsp_in_t w;
		int pick;
		int span;
		w = mcsp_in_t'($urandom);
		pick = $urandom_range(99);
		span = (pwm_period > 16'd60000) ? 40 : int'(pwm_period) + int'(pwm_trim) + 4;
		if (pick < 62) begin
			w.action = ACT_TICK;
		end else if (pick < 82) begin
			w.action = ACT_SET_WIDTH;
			w.channel = ($urandom_range(9) == 0) ? 5'($urandom_range(31, CHANNELS)) :
				5'($urandom_range(CHANNELS - 1));
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: w.value = 16'($urandom_range(span));
				6: w.value = WIDTH_KEEP_HIGH;
				7: w.value = 16'($urandom_range(pwm_trim));
				default: ;
			endcase
		end else if (pick < 86) begin
			w.action = ACT_SET_LOCK;
		end else if (pick < 91) begin
			w.action = ACT_ENABLE;
		end else if (pick < 96) begin
			w.action = ACT_DISABLE;
		end else begin
			case ($urandom_range(2))
				0: w.action = ACT_RESERVED_5;
				1: w.action = ACT_RESERVED_6;
				default: w.action = ACT_RESERVED_7;
			endcase
		end
		return w;
	endfunction

	// present one word from a falling edge; returns on the falling edge after it is taken
	task automatic send_word(input mcsp_in_t w, input bit typed, input mcsp_out_t want);
		mcsp_out_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		predicted = step_pwm(w);
		pwm_words_due.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// stop sending and let every expected word come back
	task automatic drain_results(input int holdoff);
		item_valid <= 1'b0;
		while (pwm_words_due.size() != 0)
			@(posedge clk);
		repeat (holdoff) @(posedge clk);
		@(negedge clk);
	endtask

	// write both registers back to back; only while the block is idle
	task automatic program_regs(input logic [15:0] period, input logic [7:0] trim);
		cfg_valid <= 1'b1;
		cfg_addr <= CFG_PERIOD_TICKS;
		cfg_wdata <= period;
		do @(posedge clk); while (!cfg_ready);
		pwm_period = period;
		@(negedge clk);
		// upper byte is junk, the trim register keeps only the low byte
		cfg_addr <= CFG_PULSE_TRIM;
		cfg_wdata <= {8'($urandom), trim};
		do @(posedge clk); while (!cfg_ready);
		pwm_trim = trim;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// scoreboard: every taken result word against the oldest expectation
	always @(posedge clk) begin
		mcsp_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pwm_words_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result word %h", $realtime, result);
			end else begin
				want = pwm_words_due.pop_front();
				if (result.pin_levels !== want.pin_levels) begin
					mismatches++;
					$display("%0t: pin_levels expected %h actual %h", $realtime,
						want.pin_levels, result.pin_levels);
				end
				if (result.period_start !== want.period_start) begin
					mismatches++;
					$display("%0t: period_start expected %b actual %b", $realtime,
						want.period_start, result.period_start);
				end
				if (result.running !== want.running) begin
					mismatches++;
					$display("%0t: running expected %b actual %b", $realtime,
						want.running, result.running);
				end
			end
		end
	end

	initial begin
		logic [15:0] ph_period [PHASES];
		logic [7:0] ph_trim [PHASES];

		// predictor reset state
		pwm_period = PERIOD_RESET;
		pwm_trim = TRIM_RESET;
		for (int i = 0; i < CHANNELS; i++) begin
			shadow_w[i] = WIDTH_KEEP_HIGH;
			active_w[i] = WIDTH_KEEP_HIGH;
		end
		pwm_count = '0;
		pwm_running = 1'b0;
		stop_armed = 1'b0;
		shadow_lock = 1'b0;
		pwm_pins = '0;

		// register settings per random phase: shortest, zero and longest period,
		// trim at both ends
		ph_period[0] = 16'd1;
		ph_trim[0] = 8'd0;
		ph_period[1] = 16'd20;
		ph_trim[1] = 8'd255;
		ph_period[2] = 16'd0;
		ph_trim[2] = 8'd17;
		ph_period[3] = 16'd37;
		ph_trim[3] = 8'd100;
		ph_period[4] = 16'd65535;
		ph_trim[4] = 8'd0;
		ph_period[5] = 16'($urandom_range(50, 2));
		ph_trim[5] = 8'($urandom);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table runs with a 4-tick period and trim 3
		program_regs(16'd4, 8'd3);

		// stopped block: ticks, no-op codes and width writes leave everything low
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 1, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_RESERVED_5, 5'd31, 16'hFFFF, 1, '0, 1'b0, 1'b0));
		// width below trim floors at zero
		plan.push_back(mk_row(ACT_SET_WIDTH, 5'd0, 16'd0, 1, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_SET_WIDTH, 5'd1, 16'd2, 1, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_SET_WIDTH, 5'd2, 16'hFFFF, 1, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_SET_WIDTH, 5'd17, 16'd5, 1, '0, 1'b0, 1'b0));
		// first channel past the bank is ignored
		plan.push_back(mk_row(ACT_SET_WIDTH, 5'd18, 16'd1, 1, '0, 1'b0, 1'b0));
		// lock reads bit 0 only
		plan.push_back(mk_row(ACT_SET_LOCK, 5'd0, 16'hFFFE, 1, '0, 1'b0, 1'b0));
		// enable from stop: dark lead-in period
		plan.push_back(mk_row(ACT_ENABLE, 5'd0, 16'd0, 1, '0, 1'b0, 1'b1));
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 1, '0, 1'b0, 1'b1));
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 1, '0, 1'b0, 1'b1));
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 1, '0, 1'b0, 1'b1));
		// first real period: zero widths never show, channel 17 falls at count 2
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		// locked shadows are not copied at the next period end
		plan.push_back(mk_row(ACT_SET_LOCK, 5'd0, 16'd1, 0, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_SET_WIDTH, 5'd3, 16'd10, 0, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		// enable while running changes nothing
		plan.push_back(mk_row(ACT_ENABLE, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		// disable takes hold at the period end, pins hold
		plan.push_back(mk_row(ACT_DISABLE, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		for (int i = 0; i < 4; i++)
			plan.push_back(mk_row(ACT_TICK, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));
		plan.push_back(mk_row(ACT_ENABLE, 5'd0, 16'd0, 0, '0, 1'b0, 1'b0));

		foreach (plan[i])
			send_word(plan[i].word, plan[i].typed, plan[i].want);
		drain_results(DRAIN_HOLDOFF);

		// random phases: receiver mostly stalled, then sender mostly idle, then full rate
		for (int ph = 0; ph < PHASES; ph++) begin
			program_regs(ph_period[ph], ph_trim[ph]);
			send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 87 : 0;
			recv_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 7 : 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// sender holds off mid-phase until the pipeline is empty
				if (n == PHASE_WORDS / 2)
					drain_results(0);
				send_word(rand_word(), 1'b0, '0);
			end
			drain_results(DRAIN_HOLDOFF);
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (END_HOLDOFF) @(posedge clk);
		if (mismatches == 0 && pwm_words_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[multi_channel_servo_pwm.f]
hdl/mcsp_pkg.sv
hdl/mcsp_chan_bank.sv
hdl/multi_channel_servo_pwm.sv
bench/tb_multi_channel_servo_pwm.sv
